### design/htlp_pkg.sv
// Shared definitions for the linear-probing hash table: codes, widths,
// the sequencer state type, the result bundle and the home-slot hash.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package htlp_pkg;

    // Field widths fixed by the interface.
    localparam int OP_W     = 2;
    localparam int KEY_W    = 16;
    localparam int STATUS_W = 2;
    localparam int IDX_W    = 4;

    // Default number of slots in the table.
    localparam int TABLE_DEPTH_DEF = 16;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_FIND   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_INSERT,
        S_FIND,
        S_RESP
    } state_t;

    // One result as it leaves the sequencer.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    slot_index;
    } res_t;

    // Home slot = (key * 3) mod 7. Since 8 = 1 mod 7, the key is reduced by
    // summing its octal digits and folding, then a small table applies the
    // multiplication by three.
    function automatic logic [2:0] home_slot(input logic [KEY_W-1:0] k);
        logic [5:0] s1;
        logic [3:0] s2;
        logic [3:0] s3;
        logic [2:0] r;
        logic [2:0] h;
        s1 = 6'(k[2:0]) + 6'(k[5:3]) + 6'(k[8:6]) + 6'(k[11:9])
           + 6'(k[14:12]) + 6'(k[15]);
        s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
        s3 = 4'(s2[2:0]) + 4'(s2[3]);
        r  = (s3 >= 4'd7) ? 3'(s3 - 4'd7) : s3[2:0];
        unique case (r)
            3'd0:    h = 3'd0;
            3'd1:    h = 3'd3;
            3'd2:    h = 3'd6;
            3'd3:    h = 3'd2;
            3'd4:    h = 3'd5;
            3'd5:    h = 3'd1;
            3'd6:    h = 3'd4;
            default: h = 3'd0;
        endcase
        return h;
    endfunction

endpackage

`default_nettype wire

### design/htlp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module htlp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

### design/htlp_seq.sv
// Probe sequencer: slot valid marks, probe address counter and the shared
// key compare unit. Uses htlp_pkg; drives the key RAM held at the top level.
`timescale 1ns / 1ps
`default_nettype none

module htlp_seq #(
    parameter int TABLE_DEPTH = htlp_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [htlp_pkg::OP_W-1:0]      in_op,
    input  wire logic [htlp_pkg::KEY_W-1:0]     in_key,
    output logic                                res_valid,
    input  wire logic                           res_ready,
    output htlp_pkg::res_t                      res,
    output logic                                ram_we,
    output logic [$clog2(TABLE_DEPTH)-1:0]      ram_addr,
    output logic [htlp_pkg::KEY_W-1:0]          ram_wdata,
    input  wire logic [htlp_pkg::KEY_W-1:0]     ram_rdata
);

    import htlp_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [AW-1:0] LAST = AW'(TABLE_DEPTH - 1);

    state_t                  state_reg, state_next;
    logic [KEY_W-1:0]        key_reg, key_next;
    logic [AW-1:0]           addr_reg, addr_next;
    logic [AW-1:0]           chk_addr_reg, chk_addr_next;
    logic                    chk_vld_reg, chk_vld_next;
    logic                    last_iss_reg, last_iss_next;
    logic [TABLE_DEPTH-1:0]  valid_reg, valid_next;
    logic [STATUS_W-1:0]     status_reg, status_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;

    logic free;
    logic at_last;
    logic chk_last;
    logic hit;
    logic issue;

    // Shared compare unit: slot under insert probe is free, slot whose key
    // has just come back from the RAM matches.
    assign free     = !valid_reg[addr_reg];
    assign at_last  = (addr_reg == LAST);
    assign chk_last = (chk_addr_reg == LAST);
    assign hit      = chk_vld_reg && valid_reg[chk_addr_reg] && (ram_rdata == key_reg);
    assign issue    = (state_reg == S_FIND) && !last_iss_reg
                      && !(chk_vld_reg && (hit || chk_last));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_op)
                        OP_INSERT: state_next = S_INSERT;
                        OP_FIND:   state_next = S_FIND;
                        default:   state_next = S_RESP;
                    endcase
                end
            end
            S_INSERT:
            begin
                if (free || at_last)
                begin
                    state_next = S_RESP;
                end
            end
            S_FIND:
            begin
                if (chk_vld_reg && (hit || chk_last))
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Handshake and RAM outputs.
    always_comb
    begin
        in_ready  = (state_reg == S_IDLE);
        res_valid = (state_reg == S_RESP);
        ram_we    = (state_reg == S_INSERT) && free;
    end

    assign res.status     = status_reg;
    assign res.slot_index = idx_reg;
    assign ram_addr       = addr_reg;
    assign ram_wdata      = key_reg;

    // Datapath: probe counter, check stage, valid marks and result.
    always_comb
    begin
        key_next      = key_reg;
        addr_next     = addr_reg;
        chk_addr_next = chk_addr_reg;
        chk_vld_next  = chk_vld_reg;
        last_iss_next = last_iss_reg;
        valid_next    = valid_reg;
        status_next   = status_reg;
        idx_next      = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    key_next      = in_key;
                    addr_next     = AW'(home_slot(in_key));
                    chk_vld_next  = 1'b0;
                    last_iss_next = 1'b0;
                    status_next   = ST_OK;
                    idx_next      = '0;
                    if (in_op == OP_CLEAR)
                    begin
                        valid_next = '0;
                    end
                end
            end
            S_INSERT:
            begin
                if (free)
                begin
                    valid_next[addr_reg] = 1'b1;
                    status_next          = ST_OK;
                    idx_next             = IDX_W'(addr_reg);
                end
                else if (at_last)
                begin
                    status_next = ST_FULL;
                    idx_next    = '0;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            S_FIND:
            begin
                // A read is issued at addr_reg; its key is checked next cycle.
                chk_vld_next  = issue;
                chk_addr_next = addr_reg;
                if (issue)
                begin
                    last_iss_next = at_last;
                    if (!at_last)
                    begin
                        addr_next = addr_reg + 1'b1;
                    end
                end
                if (hit)
                begin
                    status_next = ST_OK;
                    idx_next    = IDX_W'(chk_addr_reg);
                end
                else if (chk_vld_reg && chk_last)
                begin
                    status_next = ST_MISSING;
                    idx_next    = '0;
                end
            end
            S_RESP:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            chk_vld_reg  <= 1'b0;
            last_iss_reg <= 1'b0;
            valid_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            chk_vld_reg  <= chk_vld_next;
            last_iss_reg <= last_iss_next;
            valid_reg    <= valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        addr_reg     <= addr_next;
        chk_addr_reg <= chk_addr_next;
        status_reg   <= status_next;
        idx_reg      <= idx_next;
    end

    // A key write always ends the insert probe.
    a_write_ends_probe: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> (state_reg == S_RESP))
        else $error("key write not followed by result");

    // A failed operation reports slot zero.
    a_fail_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res.status == ST_FULL || res.status == ST_MISSING))
        |-> (res.slot_index == '0))
        else $error("failed operation with non-zero slot index");

    // A find finishes only on a checked slot.
    a_find_checked: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIND && state_next == S_RESP) |-> chk_vld_reg)
        else $error("find finished without a checked slot");

    // A clear leaves every slot empty.
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_op == OP_CLEAR) |=> (valid_reg == '0))
        else $error("clear left a valid slot");

endmodule

`default_nettype wire

### design/hash_table_linear_probe.sv
// Top level of the linear-probing hash table: key RAM, probe sequencer and
// the result output register. Uses htlp_pkg, htlp_ram and htlp_seq.
//
// Usage:
//   Input channel (in_valid/in_ready, op, key): one transfer per item.
//   op selects insert, find or clear of the whole table.
//   Output channel (out_valid/out_ready, status, slot_index): exactly one
//   result per item, in item order.
//   An item's probe starts at slot (key * 3) mod 7 and walks upward, one slot
//   per cycle, never past the last slot; the single key RAM port and the
//   probe counter set this pace. A find checks each key after the registered
//   RAM read; a clear or an unused op goes straight to its result.
//   in_ready is high only between items; the next item is taken the cycle
//   after the previous result enters the output register, even while that
//   result still waits for out_ready. If the receiver stalls with a result
//   already held, the sequencer holds its own result until the register
//   frees up.
//   Reset empties every slot at once; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module hash_table_linear_probe #(
    parameter int TABLE_DEPTH = htlp_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [htlp_pkg::OP_W-1:0]       op,
    input  wire logic [htlp_pkg::KEY_W-1:0]      key,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [htlp_pkg::STATUS_W-1:0]        status,
    output logic [htlp_pkg::IDX_W-1:0]           slot_index
);

    import htlp_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    logic              res_valid;
    logic              res_ready;
    res_t              res;
    logic              ram_we;
    logic [AW-1:0]     ram_addr;
    logic [KEY_W-1:0]  ram_wdata;
    logic [KEY_W-1:0]  ram_rdata;

    logic              out_valid_reg, out_valid_next;
    res_t              out_res_reg, out_res_next;

    // Key store.
    htlp_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (ram_wdata),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    // Probe sequencer.
    htlp_seq #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_op     (op),
        .in_key    (key),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_we    (ram_we),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata),
        .ram_rdata (ram_rdata)
    );

    // Output register: loads when empty or when its result is being taken.
    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_res_reg.status;
    assign slot_index = out_res_reg.slot_index;

endmodule

`default_nettype wire

### test/tb.sv
// Self-checking testbench for hash_table_linear_probe: a directed table and then
// random traffic of all four ops, checked against typed results or an in-bench predictor.
// Depends on htlp_pkg and the hash_table_linear_probe RTL.
`timescale 1ns / 1ps

module tb;
    import htlp_pkg::*;

    localparam int DEPTH            = TABLE_DEPTH_DEF;
    localparam int RANDOM_ITEMS     = 1200;
    localparam int KEY_POOL_N       = 20;
    localparam int LONG_HOLD_AT     = 500;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int PAUSE_AT         = 700;
    localparam int DRAIN_CYCLES     = 40;
    localparam int MAX_REPORTS      = 10;
    localparam int DIRECTED_N       = 24;
    localparam time TIMEOUT_NS      = 8_000_000;

    // The one op code that the block accepts but ignores.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // Row flags: the expected result is typed in, or comes from the predictor.
    localparam bit TYPED = 1'b1;
    localparam bit PRED  = 1'b0;

    typedef struct {
        logic [OP_W-1:0]     op;
        logic [KEY_W-1:0]    key;
        bit                  typed;
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    slot;
    } directed_cmd_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [OP_W-1:0]     op = OP_INSERT;
    logic [KEY_W-1:0]    key = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    slot_index;

    // Predictor copy of the table contents.
    bit               slot_used [DEPTH];
    logic [KEY_W-1:0] slot_keys [DEPTH];

    res_t             pending_results [$];
    logic [KEY_W-1:0] key_pool [KEY_POOL_N];

    int n_errors = 0;
    int n_results = 0;
    int n_offered = 0;
    int n_random = 0;
    int n_inserts = 0;
    int n_finds = 0;
    int n_clears = 0;
    int n_unused = 0;
    int n_full = 0;
    int n_missing = 0;
    int n_hits = 0;

    directed_cmd_t directed_rows [DIRECTED_N] = '{
        '{OP_FIND,   16'd0,     TYPED, ST_MISSING, 4'd0},
        '{OP_INSERT, 16'd0,     TYPED, ST_OK,      4'd0},
        '{OP_INSERT, 16'd0,     TYPED, ST_OK,      4'd1},
        '{OP_FIND,   16'd0,     TYPED, ST_OK,      4'd0},
        '{OP_INSERT, 16'hFFFF,  TYPED, ST_OK,      4'd3},
        '{OP_FIND,   16'hFFFF,  TYPED, ST_OK,      4'd3},
        '{OP_UNUSED, 16'hFFFF,  TYPED, ST_OK,      4'd0},
        '{OP_FIND,   16'd7,     TYPED, ST_MISSING, 4'd0},
        '{OP_INSERT, 16'd2,     PRED,  ST_OK,      4'd0},
        '{OP_INSERT, 16'd2,     PRED,  ST_OK,      4'd0},
        '{OP_INSERT, 16'd2,     PRED,  ST_OK,      4'd0},
        '{OP_INSERT, 16'd2,     PRED,  ST_OK,      4'd0},
        '{OP_INSERT, 16'd2,     PRED,  ST_OK,      4'd0},
        '{OP_INSERT, 16'd2,     PRED,  ST_OK,      4'd0},
        '{OP_INSERT, 16'd2,     PRED,  ST_OK,      4'd0},
        '{OP_INSERT, 16'd2,     PRED,  ST_OK,      4'd0},
        '{OP_INSERT, 16'd2,     PRED,  ST_OK,      4'd0},
        '{OP_INSERT, 16'd2,     PRED,  ST_OK,      4'd0},
        '{OP_INSERT, 16'd2,     TYPED, ST_FULL,    4'd0},
        '{OP_FIND,   16'd2,     PRED,  ST_OK,      4'd0},
        '{OP_INSERT, 16'd5,     PRED,  ST_OK,      4'd0},
        '{OP_FIND,   16'd16,    TYPED, ST_MISSING, 4'd0},
        '{OP_CLEAR,  16'd0,     TYPED, ST_OK,      4'd0},
        '{OP_FIND,   16'hFFFF,  TYPED, ST_MISSING, 4'd0}
    };

    hash_table_linear_probe i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .key        (key),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .slot_index (slot_index)
    );

    always #6 clk = ~clk;

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    // Applies one item to the predicted table and returns its result.
    function automatic res_t probe_table(input logic [OP_W-1:0] o,
                                         input logic [KEY_W-1:0] k);
        res_t r;
        int home;
        bit done;
        r.status = ST_OK;
        r.slot_index = '0;
        home = (int'(k) * 3) % 7;
        done = 1'b0;
        if (o == OP_INSERT)
        begin
            r.status = ST_FULL;
            for (int a = home; a < DEPTH && !done; a++)
            begin
                if (!slot_used[a])
                begin
                    slot_used[a] = 1'b1;
                    slot_keys[a] = k;
                    r.status = ST_OK;
                    r.slot_index = IDX_W'(a);
                    done = 1'b1;
                end
            end
        end
        else if (o == OP_FIND)
        begin
            r.status = ST_MISSING;
            for (int a = home; a < DEPTH && !done; a++)
            begin
                if (slot_used[a] && slot_keys[a] == k)
                begin
                    r.status = ST_OK;
                    r.slot_index = IDX_W'(a);
                    done = 1'b1;
                end
            end
        end
        else if (o == OP_CLEAR)
        begin
            for (int a = 0; a < DEPTH; a++)
                slot_used[a] = 1'b0;
        end
        return r;
    endfunction

    // Offers one item after an optional gap and returns once it has been transferred.
    task automatic offer_item(input logic [OP_W-1:0] o, input logic [KEY_W-1:0] k,
                              input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        key <= k;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        n_offered++;
    endtask

    // Keeps the operation tallies that the summary reports.
    task automatic tally(input logic [OP_W-1:0] o, input res_t r);
        case (o)
            OP_INSERT: n_inserts++;
            OP_FIND:   n_finds++;
            OP_CLEAR:  n_clears++;
            default:   n_unused++;
        endcase
        if (r.status == ST_FULL)
            n_full++;
        else if (r.status == ST_MISSING)
            n_missing++;
        else if (o == OP_FIND)
            n_hits++;
    endtask

    // Gap for the sender: every fourth stretch of items runs back to back.
    function automatic int sender_gap();
        if (((n_offered / 150) % 4) == 1)
            return 0;
        return idle_cycles();
    endfunction

    // Result side: random stalls, one long hold-off, and checking of each transfer.
    initial
    begin
        int stall_left;
        bit long_hold_done;
        res_t want;
        stall_left = 0;
        long_hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                n_results++;
                if (pending_results.size() == 0)
                begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("unexpected result: status %0d slot %0d",
                                 status, slot_index);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (status !== want.status || slot_index !== want.slot_index)
                    begin
                        n_errors++;
                        if (n_errors <= MAX_REPORTS)
                            $display("result %0d: expected %0d/%0d, got %0d/%0d",
                                     n_results, want.status, want.slot_index,
                                     status, slot_index);
                    end
                end
            end
            if (!long_hold_done && n_results >= LONG_HOLD_AT)
            begin
                long_hold_done = 1'b1;
                stall_left = LONG_HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (((n_results / 170) % 4) != 2)
                    stall_left = idle_cycles();
            end
        end
    end

    // Stimulus: reset, directed table, then random traffic.
    initial
    begin
        res_t r;
        int pick;
        bit paused;
        logic [OP_W-1:0] o;
        logic [KEY_W-1:0] k;
        paused = 1'b0;
        for (int a = 0; a < DEPTH; a++)
            slot_used[a] = 1'b0;
        for (int i = 0; i < KEY_POOL_N; i++)
            key_pool[i] = KEY_W'($urandom_range(0, 65535));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            offer_item(directed_rows[i].op, directed_rows[i].key, sender_gap());
            r = probe_table(directed_rows[i].op, directed_rows[i].key);
            tally(directed_rows[i].op, r);
            if (directed_rows[i].typed)
            begin
                r.status = directed_rows[i].status;
                r.slot_index = directed_rows[i].slot;
            end
            pending_results.push_back(r);
        end

        // Mostly inserts and finds on a small key pool so that finds hit and the
        // table fills; rare clears empty it again.
        while (n_random < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 47)
                o = OP_INSERT;
            else if (pick < 95)
                o = OP_FIND;
            else if (pick < 97)
                o = OP_CLEAR;
            else
                o = OP_UNUSED;
            if ($urandom_range(0, 3) != 0)
                k = key_pool[$urandom_range(0, KEY_POOL_N - 1)];
            else
                k = KEY_W'($urandom_range(0, 65535));
            offer_item(o, k, sender_gap());
            r = probe_table(o, k);
            tally(o, r);
            pending_results.push_back(r);
            if (o != OP_UNUSED)
                n_random++;

            // Once, stop offering until every result has come back.
            if (!paused && n_random >= PAUSE_AT)
            begin
                paused = 1'b1;
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while (pending_results.size() != 0);
            end
        end

        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d inserts, %0d finds (%0d hits), %0d clears, %0d ignored ops",
                 n_inserts, n_finds, n_hits, n_clears, n_unused);
        $display("saw %0d full inserts and %0d failed finds over %0d results, %0d errors",
                 n_full, n_missing, n_results, n_errors);
        if (n_errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog in case the block hangs.
    initial
    begin
        #(TIMEOUT_NS);
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
